### design/lpd_pkg.sv
// Package with the shared types, state encoding and defaults of the positional delete list.
package lpd_pkg;

    // Default list capacity in elements.
    localparam int CAPACITY_DEF = 64;

    // Request codes of the mode field.
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // One input request.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic [15:0]        position;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic signed [31:0] element;
        logic               last;
        logic               empty_res;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMIT_EMPTY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic del_start;
        logic shift_rd;
        logic shift_done;
        logic emit_rd;
        logic emit_load;
        logic emit_empty;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic len_one;
        logic shift_more;
        logic pend;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

### design/list_positional_delete_unit.sv
// Top level of the positional delete list: controller plus datapath.
//
// Usage: the input channel carries requests of type t_in_item. An append
// request writes its value at the tail and produces nothing;
// it is dropped when the list is full. A delete request removes the element
// at the clamped position and then streams the whole list, head first, on
// the output channel, with last set on the tail element. A delete that
// empties the list sends one request with empty_res and last set; a delete
// on an empty list sends nothing.
// Sequence: a delete first sets the walk counter just past the removed
// element, then reads each later element and writes it one place down
// through a pending write, waits for the last write to land and closes the
// walk by shortening the list, then emits each element by reading it from
// the element memory, whose read is registered, and then loading it into
// the output register.
// Input stall is high while a delete is in progress. The output register
// holds a result while the receiver stalls, and the walk waits on it; a
// new request can still be accepted while the last result waits.
// Reset (synchronous, active low) empties the list and clears the output.
module list_positional_delete_unit #(
    parameter int CAPACITY = lpd_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpd_pkg::t_out_item o_out_data
);
    import lpd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    lpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Storage and output path.
    lpd_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### design/lpd_ctrl.sv
// Controller state machine of the positional delete list.
module lpd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    input  lpd_pkg::t_status i_status,
    output lpd_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);
    import lpd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    // Requests enter only while the controller is idle.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in_mode == MODE_DELETE && !i_status.is_empty) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!i_status.shift_more && !i_status.pend) begin
                    n_state = i_status.len_one ? ST_EMIT_EMPTY : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMIT_EMPTY: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in_mode == MODE_APPEND && !i_status.is_full) begin
                    o_cmd.append = 1'b1;
                end
                if (in_accept && i_in_mode == MODE_DELETE && !i_status.is_empty) begin
                    o_cmd.del_start = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_status.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else if (!i_status.pend) begin
                    o_cmd.shift_done = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
            end
            ST_EMIT_OUT: begin
                o_cmd.emit_load = i_status.out_free;
            end
            ST_EMIT_EMPTY: begin
                o_cmd.emit_empty = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/lpd_dp.sv
// Datapath of the positional delete list: element memory, length, counters and output register.
module lpd_dp #(
    parameter int CAPACITY = lpd_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpd_pkg::t_in_item i_in_data,
    input  lpd_pkg::t_cmd     i_cmd,
    output lpd_pkg::t_status  o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output lpd_pkg::t_out_item o_out_data
);
    import lpd_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > 16) ? LEN_W : 16;

    logic [31:0]       mem [CAPACITY];
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_k;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [31:0]       r_rd_data;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [LEN_W-1:0]  del_idx;
    logic [LEN_W-1:0]  len_m1;
    logic              out_free;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    // Position clamp: at or past the length selects the tail.
    assign pos_ext = CMP_W'(i_in_data.position);
    assign len_ext = CMP_W'(r_len);
    assign len_m1  = r_len - LEN_W'(1);
    assign del_idx = (pos_ext >= len_ext) ? len_m1 : LEN_W'(i_in_data.position);

    assign out_free = !r_out_valid || !i_out_stall;

    // Status toward the controller.
    always_comb begin
        o_status.is_full    = (r_len == LEN_W'(CAPACITY));
        o_status.is_empty   = (r_len == '0);
        o_status.len_one    = (r_len == LEN_W'(1));
        o_status.shift_more = (r_k < r_len);
        o_status.pend       = r_pend;
        o_status.emit_last  = (r_k == len_m1);
        o_status.out_free   = out_free;
    end

    // Memory port selection.
    assign rd_en   = i_cmd.shift_rd || i_cmd.emit_rd;
    assign rd_addr = r_k[ADDR_W-1:0];
    assign wr_en   = i_cmd.append || r_pend;
    assign wr_addr = r_pend ? r_pend_addr : r_len[ADDR_W-1:0];
    assign wr_data = r_pend ? r_rd_data : i_in_data.value;

    // Element memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Destination address of the element moved down one place.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_rd) begin
            r_pend_addr <= ADDR_W'(r_k - LEN_W'(1));
        end
    end

    // Length, walk counter and pending write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_k    <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift_rd;
            if (i_cmd.append) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.shift_done) begin
                r_len <= len_m1;
            end
            if (i_cmd.del_start) begin
                r_k <= del_idx + LEN_W'(1);
            end else if (i_cmd.shift_rd || i_cmd.emit_load) begin
                r_k <= r_k + LEN_W'(1);
            end else if (i_cmd.shift_done) begin
                r_k <= '0;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out.element   <= r_rd_data;
            r_out.last      <= (r_k == len_m1);
            r_out.empty_res <= 1'b0;
        end else if (i_cmd.emit_empty) begin
            r_out.element   <= '0;
            r_out.last      <= 1'b1;
            r_out.empty_res <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length exceeds capacity");
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.append && r_pend))
        else $error("append collides with a shift write");
    a_pend_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_rd |=> r_pend)
        else $error("shift read not followed by its write");
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (r_k < r_len))
        else $error("emit index past list length");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.emit_empty) |-> out_free)
        else $error("output register overwritten while stalled");
`endif

endmodule

### tb/list_positional_delete_unit_test.sv
// Self-checking testbench of the positional delete list with a mirror-list scoreboard.
module list_positional_delete_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int RANDOM_REQUESTS = 240;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 3 * CAPACITY + 16;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HALF,
        STALL_PERIODIC
    } t_stall_style;

    // Mirror of the list contents and the queue of list elements still due.
    class list_mirror;
        int capacity;
        logic signed [31:0] elems[$];
        t_out_item due_elems[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned appends;
        int unsigned dropped;
        int unsigned deletes;
        int unsigned empty_deletes;
        int unsigned longest;

        function new(int cap);
            capacity = cap;
        endfunction

        function int pending();
            return due_elems.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Apply one accepted request to the mirror and queue the list dump it causes.
        function void note_request(t_in_item req);
            int idx;
            t_out_item item;
            if (req.mode == MODE_APPEND) begin
                appends++;
                if (elems.size() < capacity) begin
                    elems.push_back(req.value);
                end else begin
                    dropped++;
                end
                if (elems.size() > longest) begin
                    longest = elems.size();
                end
                return;
            end
            deletes++;
            if (elems.size() == 0) begin
                empty_deletes++;
                return;
            end
            // A position at or past the length removes the tail.
            idx = (int'(req.position) >= elems.size()) ? elems.size() - 1 : int'(req.position);
            elems.delete(idx);
            if (elems.size() == 0) begin
                item.element = '0;
                item.last = 1'b1;
                item.empty_res = 1'b1;
                due_elems.push_back(item);
                return;
            end
            foreach (elems[k]) begin
                item.element = elems[k];
                item.last = (k == elems.size() - 1);
                item.empty_res = 1'b0;
                due_elems.push_back(item);
            end
        endfunction

        // Compare one accepted result with the oldest element still due.
        function void check_result(t_out_item got);
            t_out_item want;
            if (due_elems.size() == 0) begin
                flag($sformatf("unexpected result: element %0d last %0b empty %0b",
                               got.element, got.last, got.empty_res));
                return;
            end
            want = due_elems.pop_front();
            checked++;
            if (got.element !== want.element || got.last !== want.last ||
                got.empty_res !== want.empty_res) begin
                flag($sformatf({"mismatch on result %0d: expected element %0d last %0b ",
                                "empty %0b, got element %0d last %0b empty %0b"},
                               checked, want.element, want.last, want.empty_res,
                               got.element, got.last, got.empty_res));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    list_mirror sb = new(CAPACITY);
    logic       holdoff_req = 1'b0;
    int         burst_left = 0;

    list_positional_delete_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Handshake monitor: every accepted request and result goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
        end
    end

    function automatic t_in_item req_of(logic mode, logic signed [31:0] value,
                                        logic [15:0] position);
        t_in_item req;
        req.mode = mode;
        req.value = value;
        req.position = position;
        return req;
    endfunction

    // Random request whose position leans toward the interesting spots of the list.
    function automatic t_in_item make_request(logic mode, int len);
        t_in_item req;
        req.mode = mode;
        case ($urandom_range(0, 7))
            0: req.value = 32'h7FFF_FFFF;
            1: req.value = 32'h8000_0000;
            2: req.value = '0;
            3: req.value = '1;
            default: req.value = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: req.position = '0;
            1: req.position = (len > 0) ? 16'(len - 1) : '0;
            2: req.position = 16'(len);
            3: req.position = 16'hFFFF;
            4: req.position = 16'($urandom_range(0, len));
            default: req.position = 16'($urandom);
        endcase
        return req;
    endfunction

    // Offer one request, in bursts with random gaps; called and returns at a falling edge.
    task automatic send_request(input t_in_item req);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            i_in_data = t_in_item'({17'($urandom), $urandom});
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_data = req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Receiver: changes its stall style per segment and serves one long hold-off.
    initial begin
        t_stall_style style;
        int seg_left;
        int phase;
        int hold_cnt;
        style = STALL_NONE;
        seg_left = 0;
        phase = 0;
        hold_cnt = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cnt != 0) begin
                hold_cnt--;
                i_out_stall = 1'b1;
            end else if (holdoff_req) begin
                holdoff_req = 1'b0;
                hold_cnt = HOLDOFF_CYCLES - 1;
                i_out_stall = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    style = t_stall_style'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 80);
                    phase = 0;
                end
                seg_left--;
                phase++;
                case (style)
                    STALL_NONE:     i_out_stall = 1'b0;
                    STALL_SPARSE:   i_out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HALF:     i_out_stall = 1'($urandom_range(0, 1));
                    STALL_PERIODIC: i_out_stall = (phase % 4 != 0);
                endcase
            end
        end
    end

    // Reset, directed requests, random requests, drain and verdict.
    initial begin
        int del_pct;
        int errors;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Delete on an empty list produces nothing.
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd0));
        // Value extremes and alternating bit patterns.
        send_request(req_of(MODE_APPEND, 32'h7FFF_FFFF, 16'hFFFF));
        send_request(req_of(MODE_APPEND, 32'h8000_0000, 16'd0));
        send_request(req_of(MODE_APPEND, 32'sd0, 16'h5555));
        send_request(req_of(MODE_APPEND, -32'sd1, 16'hAAAA));
        send_request(req_of(MODE_APPEND, 32'h5555_5555, 16'd3));
        send_request(req_of(MODE_APPEND, 32'hAAAA_AAAA, 16'd0));
        // Head removal, then positions far past and exactly at the length.
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd0));
        send_request(req_of(MODE_DELETE, 32'h1234_5678, 16'hFFFF));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd4));
        // Middle element, then the last element by its own index.
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd1));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd1));
        // Delete of the only element leaves the list empty.
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd0));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'h8000));
        // Tail removal by index, then append after it and empty again.
        send_request(req_of(MODE_APPEND, 32'sd1, 16'd0));
        send_request(req_of(MODE_APPEND, 32'sd2, 16'd0));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd1));
        send_request(req_of(MODE_APPEND, 32'sd3, 16'd0));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'hFFFF));
        send_request(req_of(MODE_DELETE, 32'sd0, 16'd0));

        // Random part: fill past capacity, drain to empty, then a mix.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == 20) begin
                holdoff_req = 1'b1;
            end
            del_pct = (i < 100) ? 15 : (i < 200) ? 80 : 50;
            send_request(make_request(($urandom_range(0, 99) < del_pct) ? MODE_DELETE
                                                                       : MODE_APPEND,
                                      sb.elems.size()));
        end
        i_in_valid = 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        errors = sb.mismatches + sb.pending();
        if (sb.pending() != 0) begin
            $display("%0d list elements never arrived", sb.pending());
        end
        $display("%0d appends (%0d dropped on a full list), %0d deletes (%0d on an empty list)",
                 sb.appends, sb.dropped, sb.deletes, sb.empty_deletes);
        $display("%0d list elements checked, longest list %0d, %0d mismatches",
                 sb.checked, sb.longest, sb.mismatches);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
